// ===== design/btmx_pkg.sv =====
// btmx_pkg: shared types, codes and default sizes for binary_trie_min_xor.
// No dependencies; used by btmx_node_mem, btmx_engine and the top level.
package btmx_pkg;

  localparam int KEY_BITS_DEF   = 32;
  localparam int POOL_NODES_DEF = 4096;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_XOR    = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_POOL_FULL = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] operand;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [31:0] min_xor;
  } out_word_t;

  // node memory strobes from the engine
  typedef struct packed {
    logic rd_en;
    logic wr_zero;
    logic wr_one;
  } mem_ctl_t;

endpackage

// ===== design/btmx_node_mem.sv =====
// btmx_node_mem: the two child-pointer memories of the trie (zero and one side).
// One shared read address, one shared write address; registered read data.
// Depends on btmx_pkg.
module btmx_node_mem #(
  parameter int POOL_NODES = btmx_pkg::POOL_NODES_DEF,
  parameter int NW         = $clog2(POOL_NODES)
) (
  input  logic                clk,
  input  btmx_pkg::mem_ctl_t  ctl,
  input  logic [NW-1:0]       rd_addr,
  input  logic [NW-1:0]       wr_addr,
  input  logic [NW-1:0]       wr_zero_data,
  input  logic [NW-1:0]       wr_one_data,
  output logic [NW-1:0]       rd_zero,
  output logic [NW-1:0]       rd_one
);

  logic [NW-1:0] zero_mem [POOL_NODES];
  logic [NW-1:0] one_mem  [POOL_NODES];

  always_ff @(posedge clk) begin
    if (ctl.wr_zero) begin
      zero_mem[wr_addr] <= wr_zero_data;
    end
    if (ctl.rd_en) begin
      rd_zero <= zero_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_one) begin
      one_mem[wr_addr] <= wr_one_data;
    end
    if (ctl.rd_en) begin
      rd_one <= one_mem[rd_addr];
    end
  end

endmodule

// ===== design/btmx_engine.sv =====
// btmx_engine: sequencer for init, insert (check walk + allocate), xor and query.
// Drives btmx_node_mem, holds mask, free pointer and the output register.
// Depends on btmx_pkg.
module btmx_engine #(
  parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
  parameter int POOL_NODES = btmx_pkg::POOL_NODES_DEF,
  parameter int NW         = $clog2(POOL_NODES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  btmx_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output btmx_pkg::out_word_t out_word,
  output btmx_pkg::mem_ctl_t  mem_ctl,
  output logic [NW-1:0]       rd_addr,
  output logic [NW-1:0]       wr_addr,
  output logic [NW-1:0]       wr_zero_data,
  output logic [NW-1:0]       wr_one_data,
  input  logic [NW-1:0]       rd_zero,
  input  logic [NW-1:0]       rd_one
);

  localparam int LW   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam bit FITS = (KEY_BITS + 1) <= POOL_NODES;
  localparam logic [NW-1:0] INIT_LAST = FITS ? NW'(KEY_BITS) : '0;
  localparam logic [NW:0]   FREE_RST  = FITS ? (NW+1)'(KEY_BITS + 1) : (NW+1)'(1);
  localparam logic [LW-1:0] LVL_TOP   = LW'(KEY_BITS - 1);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_WALK, ST_ALLOC, ST_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] mask_r, mask_nxt;
  logic [KEY_BITS-1:0] value_r, value_nxt;
  logic [NW-1:0]       node_r, node_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic [NW:0]         next_free_r, next_free_nxt;
  logic                is_query_r, is_query_nxt;
  logic                status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  btmx_pkg::out_word_t out_word_r, out_word_nxt;

  logic [KEY_BITS+31:0] op_wide;
  logic [KEY_BITS-1:0]  op_key;
  logic [KEY_BITS+31:0] val_wide;
  logic [LW-1:0]        lvl_dec;
  logic [NW:0]          nf_inc;
  logic [NW+1:0]        need_sum;
  logic                 bit_k;
  logic [NW-1:0]        child;
  logic [NW-1:0]        same;
  logic [NW-1:0]        other;
  logic [NW-1:0]        next_node;
  logic                 out_free;

  assign op_wide  = {{KEY_BITS{1'b0}}, in_word.operand};
  assign op_key   = op_wide[KEY_BITS-1:0];
  assign val_wide = {32'd0, value_r};
  assign lvl_dec  = lvl_r - 1'b1;
  assign nf_inc   = next_free_r + 1'b1;
  // nodes still missing at this level: lvl_r + 1
  assign need_sum = {1'b0, next_free_r} + (NW+2)'(lvl_r) + 1'b1;
  assign bit_k    = is_query_r ? mask_r[lvl_r] : key_r[lvl_r];
  assign child    = bit_k ? rd_one : rd_zero;
  assign same     = child;
  assign other    = bit_k ? rd_zero : rd_one;
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    mask_nxt      = mask_r;
    value_nxt     = value_r;
    node_nxt      = node_r;
    lvl_nxt       = lvl_r;
    next_free_nxt = next_free_r;
    is_query_nxt  = is_query_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    mem_ctl       = '0;
    rd_addr       = '0;
    wr_addr       = '0;
    wr_zero_data  = '0;
    wr_one_data   = '0;
    next_node     = '0;

    unique case (state_r)
      ST_INIT: begin
        // lay down the key-zero path: node n -> zero child n+1
        mem_ctl.wr_zero = 1'b1;
        mem_ctl.wr_one  = 1'b1;
        wr_addr         = node_r;
        if (FITS && ({1'b0, node_r} < (NW+1)'(KEY_BITS))) begin
          wr_zero_data = node_r + 1'b1;
        end
        if (node_r == INIT_LAST) begin
          node_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          node_nxt = node_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          value_nxt  = '0;
          status_nxt = btmx_pkg::STATUS_OK;
          node_nxt   = '0;
          lvl_nxt    = LVL_TOP;
          case (in_word.func)
            btmx_pkg::FUNC_INSERT: begin
              key_nxt        = op_key ^ mask_r;
              is_query_nxt   = 1'b0;
              mem_ctl.rd_en  = 1'b1;
              state_nxt      = ST_WALK;
            end
            btmx_pkg::FUNC_XOR: begin
              mask_nxt  = mask_r ^ op_key;
              state_nxt = ST_FINISH;
            end
            btmx_pkg::FUNC_QUERY: begin
              is_query_nxt  = 1'b1;
              mem_ctl.rd_en = 1'b1;
              state_nxt     = ST_WALK;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      ST_WALK: begin
        // children of node_r are on the memory outputs
        if (is_query_r) begin
          if (same != '0) begin
            next_node = same;
          end else if (other != '0) begin
            next_node        = other;
            value_nxt[lvl_r] = 1'b1;
          end
          if (same == '0 && other == '0) begin
            value_nxt = '0;
            state_nxt = ST_FINISH;
          end else if (lvl_r == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            node_nxt      = next_node;
            lvl_nxt       = lvl_dec;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = next_node;
          end
        end else if (child != '0) begin
          if (lvl_r == '0) begin
            state_nxt = ST_FINISH;  // key already present
          end else begin
            node_nxt      = child;
            lvl_nxt       = lvl_dec;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = child;
          end
        end else if (need_sum > (NW+2)'(POOL_NODES)) begin
          status_nxt = btmx_pkg::STATUS_POOL_FULL;
          state_nxt  = ST_FINISH;
        end else begin
          // hook the first new node onto the existing parent
          wr_addr = node_r;
          if (bit_k) begin
            mem_ctl.wr_one = 1'b1;
            wr_one_data    = next_free_r[NW-1:0];
          end else begin
            mem_ctl.wr_zero = 1'b1;
            wr_zero_data    = next_free_r[NW-1:0];
          end
          state_nxt = ST_ALLOC;
        end
      end

      ST_ALLOC: begin
        // new node at next_free_r sits below level lvl_r
        mem_ctl.wr_zero = 1'b1;
        mem_ctl.wr_one  = 1'b1;
        wr_addr         = next_free_r[NW-1:0];
        next_free_nxt   = nf_inc;
        if (lvl_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          if (key_r[lvl_dec]) begin
            wr_one_data = nf_inc[NW-1:0];
          end else begin
            wr_zero_data = nf_inc[NW-1:0];
          end
          lvl_nxt = lvl_dec;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_word_nxt.status  = status_r;
          out_word_nxt.min_xor = val_wide[31:0];
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      mask_r      <= '0;
      node_r      <= '0;
      lvl_r       <= '0;
      next_free_r <= FREE_RST;
      is_query_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      node_r      <= node_nxt;
      lvl_r       <= lvl_nxt;
      next_free_r <= next_free_nxt;
      is_query_r  <= is_query_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    value_r    <= value_nxt;
    status_r   <= status_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// ===== design/binary_trie_min_xor.sv =====
// binary_trie_min_xor: top level of the binary trie with lazy xor mask.
// Depends on btmx_pkg, btmx_node_mem and btmx_engine.
//
// Each input word is one operation: insert (store operand ^ mask), xor (fold
// operand into the mask) or query (least stored key ^ mask); every word gives
// exactly one result word. One operation is handled at a time and the pace is
// set by the child-pointer memories, whose registered read data allows one
// trie level per cycle. A new word is taken while the previous result still
// waits in the output register. After reset the block writes the root and the
// key-zero path (only the root when that path does not fit in the pool) and
// stalls input meanwhile.
// Pool nodes at or above the free pointer are never read, so the memories
// need no full clearing pass; each node's children are written as it is
// allocated. A rejected insert (pool full) returns status 1 and leaves the
// trie untouched.
module binary_trie_min_xor #(
  parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
  parameter int POOL_NODES = btmx_pkg::POOL_NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  btmx_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output btmx_pkg::out_word_t out_word
);

  localparam int NW = $clog2(POOL_NODES);

  btmx_pkg::mem_ctl_t mem_ctl;
  logic [NW-1:0]      rd_addr;
  logic [NW-1:0]      wr_addr;
  logic [NW-1:0]      wr_zero_data;
  logic [NW-1:0]      wr_one_data;
  logic [NW-1:0]      rd_zero;
  logic [NW-1:0]      rd_one;

  // sequencer: walks, allocates, holds mask and result register
  btmx_engine #(
    .KEY_BITS   (KEY_BITS),
    .POOL_NODES (POOL_NODES),
    .NW         (NW)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .mem_ctl      (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_zero_data (wr_zero_data),
    .wr_one_data  (wr_one_data),
    .rd_zero      (rd_zero),
    .rd_one       (rd_one)
  );

  // child pointers; index 0 is the root and doubles as null
  btmx_node_mem #(
    .POOL_NODES (POOL_NODES),
    .NW         (NW)
  ) u_node_mem (
    .clk          (clk),
    .ctl          (mem_ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_zero_data (wr_zero_data),
    .wr_one_data  (wr_one_data),
    .rd_zero      (rd_zero),
    .rd_one       (rd_one)
  );

endmodule

// ===== verif/tb_binary_trie_min_xor.sv =====
// tb_binary_trie_min_xor: self-checking testbench for the binary trie min-xor block.
// Depends on btmx_pkg and binary_trie_min_xor; a scoreboard class keeps its own trie,
// mask and free pointer, and tasks drive randomized words with random idling.
module tb_binary_trie_min_xor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         POOL        = btmx_pkg::POOL_NODES_DEF;
  localparam int         KEYW        = btmx_pkg::KEY_BITS_DEF;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;   // spare code, must act as a no-op
  localparam int         RAND_WORDS  = 430;
  localparam int         FILL_WORDS  = 200;    // insert-heavy opening of the random part
  localparam int         CALM_WORDS  = 60;     // tail with no idling on either side
  localparam int         HOLD_AT     = 150;    // random word index that triggers the long hold
  localparam int         HOLD_CYCLES = 400;
  localparam int         DRAIN_WAIT  = 2 * KEYW + 16;
  // No-accept stretch of a correct run is at most the long hold plus a stall burst,
  // a sender gap and one full insert; the limit is many times that.
  localparam int         IDLE_LIMIT  = 5000;

  // Keeps a private copy of the trie and predicts every result word in order.
  class trie_scoreboard;
    int unsigned         zero_kid [POOL];
    int unsigned         one_kid  [POOL];
    int unsigned         free_node;
    logic [31:0]         mask;
    btmx_pkg::out_word_t pending_results [$];
    int                  errors, checked;
    int                  n_ins, n_rej, n_xor, n_qry, n_nop;

    function new();
      foreach (zero_kid[i]) begin
        zero_kid[i] = 0;
        one_kid[i]  = 0;
      end
      free_node = 1;
      mask      = '0;
      errors    = 0;
      checked   = 0;
      n_ins = 0; n_rej = 0; n_xor = 0; n_qry = 0; n_nop = 0;
      void'(add_key('0));   // reset leaves key zero in the trie
    endfunction

    // Count missing nodes first; only grow the path when all of them fit.
    function bit add_key(logic [31:0] key);
      int unsigned node, kid, missing;
      int i;
      node    = 0;
      missing = 0;
      for (i = KEYW - 1; i >= 0; i--) begin
        kid = key[i] ? one_kid[node] : zero_kid[node];
        if (kid == 0) begin
          missing = i + 1;
          break;
        end
        node = kid;
      end
      if (free_node + missing > POOL) return 1'b0;
      node = 0;
      for (i = KEYW - 1; i >= 0; i--) begin
        kid = key[i] ? one_kid[node] : zero_kid[node];
        if (kid == 0) begin
          kid = free_node;
          free_node++;
          zero_kid[kid] = 0;
          one_kid[kid]  = 0;
          if (key[i]) one_kid[node] = kid;
          else zero_kid[node] = kid;
        end
        node = kid;
      end
      return 1'b1;
    endfunction

    // Greedy walk: follow the child equal to the mask bit, else pay for that bit.
    function logic [31:0] least_xor();
      logic [31:0] value;
      int unsigned node, same, other;
      int i;
      value = '0;
      node  = 0;
      for (i = KEYW - 1; i >= 0; i--) begin
        same  = mask[i] ? one_kid[node] : zero_kid[node];
        other = mask[i] ? zero_kid[node] : one_kid[node];
        if (same != 0) begin
          node = same;
        end else if (other != 0) begin
          value[i] = 1'b1;
          node     = other;
        end else begin
          return '0;
        end
      end
      return value;
    endfunction

    function void note_word(btmx_pkg::in_word_t w);
      btmx_pkg::out_word_t r;
      r = '0;
      case (w.func)
        btmx_pkg::FUNC_INSERT: begin
          n_ins++;
          if (!add_key(w.operand ^ mask)) begin
            r.status = btmx_pkg::STATUS_POOL_FULL;
            n_rej++;
          end
        end
        btmx_pkg::FUNC_XOR: begin
          n_xor++;
          mask = mask ^ w.operand;
        end
        btmx_pkg::FUNC_QUERY: begin
          n_qry++;
          r.min_xor = least_xor();
        end
        default: n_nop++;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_word(btmx_pkg::out_word_t got);
      btmx_pkg::out_word_t want;
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing pending: status %0b min_xor %08h",
                   got.status, got.min_xor);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.min_xor !== want.min_xor) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected status %0b min_xor %08h, got status %0b min_xor %08h",
                   checked, want.status, want.min_xor, got.status, got.min_xor);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  btmx_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  btmx_pkg::out_word_t out_word;

  trie_scoreboard sb;

  // Stimulus-side view of the mask and of keys already offered, so that many
  // inserts land next to stored keys and many xors make a stored key the minimum.
  logic [31:0] gen_mask;
  logic [31:0] keys_seen [$];
  bit          calm;        // set for the tail: no gaps, no stalls
  bit          long_hold;   // request for the long receiver hold, taken once
  int          idle_cycles;

  binary_trie_min_xor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one word, maybe after a random gap, and hold it until the block takes it.
  // Valid gets exactly one assignment per edge, so back-to-back words keep it high.
  task automatic send_word(input btmx_pkg::in_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_word  <= {2'($urandom_range(0, 3)), $urandom};   // junk while idle, ignored
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  // Random word; fill mode leans on fresh keys to drive the pool toward full.
  task automatic pick_word(input bit fill, output btmx_pkg::in_word_t w);
    int          r;
    logic [31:0] base;
    r         = $urandom_range(0, 99);
    w.operand = $urandom;
    if (r < (fill ? 70 : 40)) begin
      w.func = btmx_pkg::FUNC_INSERT;
      if (keys_seen.size() > 0 && $urandom_range(0, 99) >= (fill ? 80 : 45)) begin
        // near an existing key: only the last few levels are new
        base      = keys_seen[$urandom_range(0, keys_seen.size() - 1)];
        base      = base ^ ($urandom & ((32'd1 << $urandom_range(1, 12)) - 32'd1));
        w.operand = base ^ gen_mask;
      end
      keys_seen.push_back(w.operand ^ gen_mask);
    end else if (r < (fill ? 80 : 62)) begin
      w.func = btmx_pkg::FUNC_XOR;
      if (keys_seen.size() > 0 && $urandom_range(0, 2) == 0)
        w.operand = keys_seen[$urandom_range(0, keys_seen.size() - 1)] ^ gen_mask;
      gen_mask = gen_mask ^ w.operand;
    end else if (r < 95) begin
      w.func = btmx_pkg::FUNC_QUERY;
    end else begin
      w.func = FUNC_UNUSED;
    end
  endtask

  task automatic send_op(input logic [1:0] f, input logic [31:0] v);
    btmx_pkg::in_word_t w;
    w.func    = f;
    w.operand = v;
    if (f == btmx_pkg::FUNC_XOR) gen_mask = gen_mask ^ v;
    if (f == btmx_pkg::FUNC_INSERT) keys_seen.push_back(v ^ gen_mask);
    send_word(w);
  endtask

  // Receiver: random stall bursts, plain stretches, and one long hold on request.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!calm && long_hold && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Result monitor: sample pre-edge values, so ordering inside the step is irrelevant.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
  end

  // Watchdog on cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles with no word moving, %0d results outstanding",
               idle_cycles, sb.pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    btmx_pkg::in_word_t w;
    int                 i;
    sb          = new();
    gen_mask    = '0;
    calm        = 1'b0;
    long_hold   = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: trie holding only key zero, field extremes, every code, masks on and off.
    send_op(btmx_pkg::FUNC_QUERY,  32'h0000_0000);   // only key zero stored
    send_op(btmx_pkg::FUNC_INSERT, 32'h0000_0000);   // path already there, nothing allocated
    send_op(btmx_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
    send_op(btmx_pkg::FUNC_QUERY,  32'hFFFF_FFFF);   // operand ignored on query
    send_op(btmx_pkg::FUNC_XOR,    32'hFFFF_FFFF);   // all-ones key now xors to zero
    send_op(btmx_pkg::FUNC_QUERY,  32'h0000_0000);
    send_op(btmx_pkg::FUNC_XOR,    32'h8000_0001);
    send_op(btmx_pkg::FUNC_QUERY,  32'h0000_0000);
    send_op(btmx_pkg::FUNC_INSERT, 32'hAAAA_5555);
    send_op(btmx_pkg::FUNC_INSERT, 32'h0000_0001);
    send_op(btmx_pkg::FUNC_INSERT, 32'h8000_0000);
    send_op(btmx_pkg::FUNC_QUERY,  32'h0000_0000);
    send_op(FUNC_UNUSED,           32'hFFFF_FFFF);   // spare code: no effect at all
    send_op(FUNC_UNUSED,           32'h0000_0000);
    send_op(btmx_pkg::FUNC_XOR,    32'h0000_0000);
    send_op(btmx_pkg::FUNC_QUERY,  32'h5555_AAAA);
    send_op(btmx_pkg::FUNC_XOR,    32'h7FFF_FFFF);
    send_op(btmx_pkg::FUNC_QUERY,  32'h0000_0000);
    send_op(btmx_pkg::FUNC_INSERT, 32'h5555_AAAA);
    send_op(btmx_pkg::FUNC_QUERY,  32'h0000_0000);

    // Random: insert-heavy first to exhaust the pool, then a broad mix where most
    // inserts hit the full-pool check, some still fit next to existing keys.
    for (i = 0; i < RAND_WORDS; i++) begin
      if (i == HOLD_AT) long_hold = 1'b1;   // sender keeps offering during the hold
      if (i == RAND_WORDS - CALM_WORDS) calm = 1'b1;
      pick_word(i < FILL_WORDS, w);
      send_word(w);
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);   // catch any stray extra result

    $display("covered %0d inserts (%0d refused, pool full), %0d xors, %0d queries, %0d no-ops",
             sb.n_ins, sb.n_rej, sb.n_xor, sb.n_qry, sb.n_nop);
    $display("%0d of %0d pool nodes used, %0d results checked, %0d mismatches",
             sb.free_node, POOL, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
